@@ hw/rtl/ax25_frame_header_parser_macros.svh @@
// assertion macros for the frame header parser, included by ax25fh_parser
`ifndef AX25_FRAME_HEADER_PARSER_MACROS_SVH
`define AX25_FRAME_HEADER_PARSER_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define AX25FH_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define AX25FH_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AX25FH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ax25fh_pkg.sv @@
// types and constants of the ax.25 frame header parser
package ax25fh_pkg;

    // most repeater addresses a frame may carry
    localparam int unsigned MAX_REPEATERS = 8;
    // destination and source come before the repeaters
    localparam int unsigned ADDR_LIMIT = 2 + MAX_REPEATERS;
    localparam int unsigned COUNT_W = $clog2(ADDR_LIMIT + 1);

    localparam logic [2:0] SSID_POS = 3'd6;
    localparam logic [7:0] PID_ESCAPE = 8'hff;
    localparam logic [7:0] UI_MASK = 8'hef;
    localparam logic [7:0] UI_CODE = 8'h03;

    typedef enum logic [3:0] {
        KIND_DST_CHAR = 4'd0,
        KIND_DST_SSID = 4'd1,
        KIND_SRC_CHAR = 4'd2,
        KIND_SRC_SSID = 4'd3,
        KIND_RPT_CHAR = 4'd4,
        KIND_RPT_SSID = 4'd5,
        KIND_CONTROL  = 4'd6,
        KIND_PID      = 4'd7,
        KIND_INFO     = 4'd8,
        KIND_DISCARD  = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ADDR  = 3'd1,
        ST_TOO_MANY  = 3'd2,
        ST_MULTI_PID = 3'd3,
        ST_NO_PID    = 3'd4,
        ST_NO_INFO   = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        PH_ADDR    = 5'b00001,
        PH_CTRL    = 5'b00010,
        PH_PID     = 5'b00100,
        PH_INFO    = 5'b01000,
        PH_DISCARD = 5'b10000
    } phase_t;

    // one frame byte request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_frame;
    } byte_req_t;

    // one labelled byte
    typedef struct packed {
        kind_t      byte_kind;
        logic [7:0] field_value;
        logic [2:0] repeater_slot;
        logic [2:0] char_position;
        logic       frame_done;
        status_t    frame_status;
    } result_t;

    // handshake between two internal stages
    typedef struct packed {
        logic valid;
        logic take;
    } stage_ctl_t;

endpackage

@@ hw/rtl/ax25fh_if.sv @@
// channel interfaces for frame bytes and labelled results
interface ax25fh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_frame;

    modport source (output valid, output in_byte, output end_of_frame, input ready);
    modport sink (input valid, input in_byte, input end_of_frame, output ready);
endinterface

interface ax25fh_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] byte_kind;
    logic [7:0] field_value;
    logic [2:0] repeater_slot;
    logic [2:0] char_position;
    logic       frame_done;
    logic [2:0] frame_status;

    modport source (
        output valid, output byte_kind, output field_value, output repeater_slot,
        output char_position, output frame_done, output frame_status, input ready
    );
    modport sink (
        input valid, input byte_kind, input field_value, input repeater_slot,
        input char_position, input frame_done, input frame_status, output ready
    );
endinterface

@@ hw/rtl/ax25fh_in_reg.sv @@
// input register holding one frame byte request
module ax25fh_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    ax25fh_in_if.sink          bytes,
    input  logic               req_take,
    output logic               req_valid,
    output ax25fh_pkg::byte_req_t req
);
    import ax25fh_pkg::*;

    logic      valid_reg;
    byte_req_t req_reg;
    logic      accept;

    // free when empty or when the held request moves on this cycle
    assign bytes.ready = !valid_reg || req_take;
    assign accept = bytes.valid && bytes.ready;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (req_take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.in_byte <= bytes.in_byte;
            req_reg.end_of_frame <= bytes.end_of_frame;
        end
    end

    assign req_valid = valid_reg;
    assign req = req_reg;

endmodule

@@ hw/rtl/ax25fh_parser.sv @@
// frame parse state and per-byte labelling logic
`include "ax25_frame_header_parser_macros.svh"

module ax25fh_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  ax25fh_pkg::byte_req_t req,
    input  logic                  res_ready,
    output ax25fh_pkg::stage_ctl_t ctl,
    output ax25fh_pkg::result_t   res
);
    import ax25fh_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [2:0]         pos_reg, pos_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            err_reg, err_next;
    logic               needs_pid;
    logic               is_rpt;
    logic               take;
    status_t            status;
    logic [7:0]         b;

    assign b = req.in_byte;
    assign take = req_valid && res_ready;
    assign ctl.valid = req_valid;
    assign ctl.take = take;
    assign is_rpt = (count_reg >= COUNT_W'(2));

    // label the byte and work out the next parse state
    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        count_next = count_reg;
        err_next = err_reg;
        needs_pid = 1'b0;
        status = ST_OK;
        res.byte_kind = KIND_DISCARD;
        res.field_value = b;
        res.repeater_slot = 3'd0;
        res.char_position = 3'd0;
        res.frame_done = req.end_of_frame;

        case (phase_reg)
            PH_ADDR:
            begin
                if (pos_reg == 3'd0 && count_reg >= COUNT_W'(ADDR_LIMIT))
                begin
                    err_next = ST_TOO_MANY;
                    phase_next = PH_DISCARD;
                end
                else if (pos_reg < SSID_POS && b[0])
                begin
                    err_next = ST_BAD_ADDR;
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    if (is_rpt)
                    begin
                        res.repeater_slot = count_reg[2:0] - 3'd2;
                    end
                    res.char_position = pos_reg;
                    if (pos_reg < SSID_POS)
                    begin
                        // callsign character
                        if (count_reg == COUNT_W'(0))
                            res.byte_kind = KIND_DST_CHAR;
                        else if (count_reg == COUNT_W'(1))
                            res.byte_kind = KIND_SRC_CHAR;
                        else
                            res.byte_kind = KIND_RPT_CHAR;
                        res.field_value = {1'b0, b[7:1]};
                        pos_next = pos_reg + 3'd1;
                        if (req.end_of_frame)
                            status = ST_BAD_ADDR;
                    end
                    else
                    begin
                        // ssid byte, extension bit ends the address field
                        if (count_reg == COUNT_W'(0))
                            res.byte_kind = KIND_DST_SSID;
                        else if (count_reg == COUNT_W'(1))
                            res.byte_kind = KIND_SRC_SSID;
                        else
                            res.byte_kind = KIND_RPT_SSID;
                        pos_next = 3'd0;
                        if (b[0])
                            phase_next = PH_CTRL;
                        else
                            count_next = count_reg + COUNT_W'(1);
                    end
                end
            end
            PH_CTRL:
            begin
                // i frame or ui frame carries a pid
                res.byte_kind = KIND_CONTROL;
                needs_pid = !b[0] || ((b & UI_MASK) == UI_CODE);
                phase_next = needs_pid ? PH_PID : PH_INFO;
                if (req.end_of_frame && needs_pid)
                    status = ST_NO_PID;
            end
            PH_PID:
            begin
                if (b == PID_ESCAPE)
                begin
                    err_next = ST_MULTI_PID;
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    res.byte_kind = KIND_PID;
                    phase_next = PH_INFO;
                    if (req.end_of_frame)
                        status = ST_NO_INFO;
                end
            end
            PH_INFO:
            begin
                res.byte_kind = KIND_INFO;
            end
            PH_DISCARD:
            begin
                res.byte_kind = KIND_DISCARD;
            end
            default:
            begin
                res.byte_kind = KIND_DISCARD;
            end
        endcase

        // first error wins, status only on the last byte
        if (err_next != ST_OK)
            status = err_next;
        if (!req.end_of_frame)
            status = ST_OK;
        res.frame_status = status;

        // back to the start for the next frame
        if (req.end_of_frame)
        begin
            phase_next = PH_ADDR;
            pos_next = 3'd0;
            count_next = '0;
            err_next = ST_OK;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ADDR;
            pos_reg <= 3'd0;
            count_reg <= '0;
            err_reg <= ST_OK;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            count_reg <= count_next;
            err_reg <= err_next;
        end
    end

    `AX25FH_ASSERT_ALWAYS(a_pos_range, pos_reg <= SSID_POS, "address offset out of range")
    `AX25FH_ASSERT_ALWAYS(a_count_range, count_reg <= COUNT_W'(ADDR_LIMIT), "address count too high")
    `AX25FH_ASSERT_NEXT(a_frame_restart, take && req.end_of_frame, phase_reg == PH_ADDR && pos_reg == 3'd0 && count_reg == '0 && err_reg == ST_OK, "parser not reset after frame end")
    `AX25FH_ASSERT_IMPLIES(a_err_discard, err_reg != ST_OK, phase_reg == PH_DISCARD, "error held outside discard phase")
    `AX25FH_ASSERT_IMPLIES(a_status_on_end, req_valid && !req.end_of_frame, res.frame_status == ST_OK, "status given before frame end")

endmodule

@@ hw/rtl/ax25fh_out_reg.sv @@
// result register driving the labelled byte channel
module ax25fh_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  ax25fh_pkg::result_t res,
    output logic                res_ready,
    ax25fh_out_if.source        labels
);
    import ax25fh_pkg::*;

    logic    valid_reg;
    result_t res_reg;
    logic    load;

    // take a new result when empty or when the held one leaves
    assign res_ready = !valid_reg || labels.ready;
    assign load = res_valid && res_ready;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign labels.valid = valid_reg;
    assign labels.byte_kind = res_reg.byte_kind;
    assign labels.field_value = res_reg.field_value;
    assign labels.repeater_slot = res_reg.repeater_slot;
    assign labels.char_position = res_reg.char_position;
    assign labels.frame_done = res_reg.frame_done;
    assign labels.frame_status = res_reg.frame_status;

endmodule

@@ hw/rtl/ax25_frame_header_parser.sv @@
// top level of the ax.25 frame header parser
//
//   channel        side   carries
//   frame_bytes    sink   in_byte, end_of_frame
//   byte_labels    source byte_kind, field_value, repeater_slot, char_position,
//                         frame_done, frame_status
//
// one byte per cycle sustained while byte_labels does not stall; a request reaches its
// labelled result through the input register, then parse logic into the result register
// the parse state updates when a byte moves from the input to the result register
// asynchronous reset empties both registers and returns the parser to address phase
// a stall on byte_labels fills the result and input registers, then drops ready
module ax25_frame_header_parser (
    input  logic         clk,
    input  logic         rst_n,
    ax25fh_in_if.sink    frame_bytes,
    ax25fh_out_if.source byte_labels
);
    import ax25fh_pkg::*;

    logic       req_valid;
    byte_req_t  req;
    result_t    res;
    logic       res_ready;
    stage_ctl_t ctl;

    // input register
    ax25fh_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (frame_bytes),
        .req_take  (ctl.take),
        .req_valid (req_valid),
        .req       (req)
    );

    // parse state and labelling
    ax25fh_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .res_ready (res_ready),
        .ctl       (ctl),
        .res       (res)
    );

    // result register
    ax25fh_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (ctl.valid),
        .res       (res),
        .res_ready (res_ready),
        .labels    (byte_labels)
    );

endmodule
